>>> sv/uartrx_pkg.sv
// ----------------------------------------------------------------------------
// UART receiver package
// Shared types and constants for the UART receiver with receive FIFO.
// ----------------------------------------------------------------------------
package uartrx_pkg;

  localparam int FIFO_DEPTH_DEFAULT = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RX_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_EN    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_STOP     = 2'd3;

  localparam logic [CFG_DATA_W-1:0] HALF_BIT_RESET = 16'd434;

  localparam int FRAME_W    = 12;
  localparam int FRAME_BASE = 10;
  localparam int DATA_BITS  = 8;
  localparam int FILL_W     = 7;

  localparam int CMD_QUEUE_DEPTH = 4;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef struct packed {
    logic                 is_pop;
    logic [DATA_BITS-1:0] data;
  } cmd_t;

endpackage

>>> sv/uartrx_front.sv
// ----------------------------------------------------------------------------
// UART receiver front end
// Accepts items, holds the configuration, runs the half-bit timer, the
// sampler and the frame check, and issues push and pop commands.
// ----------------------------------------------------------------------------
module uartrx_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [uartrx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [uartrx_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic                                line_level,
  output logic                                cmd_valid,
  output uartrx_pkg::cmd_t                    cmd,
  input  logic                                cmd_ready
);

  localparam int FW = uartrx_pkg::FRAME_W;
  localparam int DW = uartrx_pkg::DATA_BITS;

  logic                                receiver_enable;
  logic [uartrx_pkg::CFG_DATA_W-1:0]   half_bit_ticks;
  logic                                parity_enable;
  logic                                two_stop_bits;

  logic [15:0]   tick_counter, tick_counter_next;
  logic          sample_phase, sample_phase_next;
  logic          first_sample, first_sample_next;
  logic [FW-1:0] frame_shift, frame_shift_next;
  logic [3:0]    bits_collected, bits_collected_next;

  logic [16:0]   tick_sum;
  logic          take_sample;
  logic          bit_ready;
  logic          bit_value;
  logic [3:0]    fsize;
  logic [3:0]    par_pos;
  logic [FW-1:0] shifted;
  logic          frame_ok;
  logic [DW-1:0] frame_data;
  logic          accept;
  logic          tick_go;

  assign in_ready = cmd_ready;
  assign accept   = in_valid && in_ready;
  assign tick_go  = accept && (req_type == uartrx_pkg::REQ_TICK) && receiver_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      receiver_enable <= 1'b1;
      half_bit_ticks  <= uartrx_pkg::HALF_BIT_RESET;
      parity_enable   <= 1'b0;
      two_stop_bits   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        uartrx_pkg::CFG_RX_ENABLE: receiver_enable <= cfg_data[0];
        uartrx_pkg::CFG_HALF_BIT:  half_bit_ticks  <= cfg_data;
        uartrx_pkg::CFG_PARITY_EN: parity_enable   <= cfg_data[0];
        uartrx_pkg::CFG_TWO_STOP:  two_stop_bits   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tick_sum            = {1'b0, tick_counter} + 17'd1;
    take_sample         = tick_sum >= {1'b0, half_bit_ticks};
    tick_counter_next   = take_sample ? 16'd0 : tick_sum[15:0];
    sample_phase_next   = sample_phase;
    first_sample_next   = first_sample;
    bit_ready           = 1'b0;
    bit_value           = 1'b0;
    if (take_sample) begin
      if (!sample_phase) begin
        first_sample_next = line_level;
        sample_phase_next = 1'b1;
      end else if (line_level == first_sample) begin
        sample_phase_next = 1'b0;
        bit_ready         = 1'b1;
        bit_value         = line_level;
      end else begin
        first_sample_next = line_level;
        sample_phase_next = 1'b1;
        bit_ready         = 1'b1;
        bit_value         = first_sample;
      end
    end

    fsize   = 4'(uartrx_pkg::FRAME_BASE) + {3'b0, two_stop_bits} + {3'b0, parity_enable};
    par_pos = fsize - 4'd2 - {3'b0, two_stop_bits};
    shifted = {1'b0, frame_shift[FW-1:1]} | (FW'(bit_value) << (fsize - 4'd1));

    frame_shift_next    = frame_shift;
    bits_collected_next = bits_collected;
    frame_ok            = 1'b0;
    frame_data          = shifted[DW:1];
    if (bit_ready) begin
      frame_shift_next = shifted;
      if (bits_collected < fsize) begin
        bits_collected_next = bits_collected + 4'd1;
      end else begin
        bits_collected_next = fsize;
      end
      if (bits_collected_next == fsize) begin
        frame_ok = !shifted[0] && shifted[fsize - 4'd1] &&
                   (!two_stop_bits || shifted[fsize - 4'd2]) &&
                   (!parity_enable || (shifted[par_pos] == ^frame_data));
      end
      if (frame_ok) begin
        bits_collected_next = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter   <= '0;
      sample_phase   <= 1'b0;
      first_sample   <= 1'b0;
      frame_shift    <= '0;
      bits_collected <= '0;
    end else if (tick_go) begin
      tick_counter   <= tick_counter_next;
      sample_phase   <= sample_phase_next;
      first_sample   <= first_sample_next;
      frame_shift    <= frame_shift_next;
      bits_collected <= bits_collected_next;
    end
  end

  assign cmd_valid  = accept && ((req_type == uartrx_pkg::REQ_POP) || (tick_go && frame_ok));
  assign cmd.is_pop = (req_type == uartrx_pkg::REQ_POP);
  assign cmd.data   = frame_data;

endmodule

>>> sv/uartrx_queue.sv
// ----------------------------------------------------------------------------
// UART receiver command queue
// Short first-in first-out queue of push and pop commands between the
// front end and the FIFO back end.
// ----------------------------------------------------------------------------
module uartrx_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  uartrx_pkg::cmd_t wr_cmd,
  output logic             rd_valid,
  input  logic             rd_ready,
  output uartrx_pkg::cmd_t rd_cmd
);

  localparam int QD = uartrx_pkg::CMD_QUEUE_DEPTH;
  localparam int PW = $clog2(QD);
  localparam int CW = $clog2(QD + 1);

  uartrx_pkg::cmd_t entries [QD];
  logic [PW-1:0]    head;
  logic [PW-1:0]    tail;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = count != CW'(QD);
  assign rd_valid = count != '0;
  assign rd_cmd   = entries[head];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[tail] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        tail <= (tail == PW'(QD - 1)) ? '0 : tail + PW'(1);
      end
      if (do_rd) begin
        head <= (head == PW'(QD - 1)) ? '0 : head + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> sv/uartrx_back.sv
// ----------------------------------------------------------------------------
// UART receiver FIFO back end
// Carries out push and pop commands on the receive FIFO memory and holds
// the result item in the output register.
// ----------------------------------------------------------------------------
module uartrx_back #(
  parameter int FIFO_DEPTH = uartrx_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  uartrx_pkg::cmd_t                  cmd,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [uartrx_pkg::DATA_BITS-1:0]  rx_data,
  output logic                              data_valid,
  output logic [uartrx_pkg::FILL_W-1:0]     fill_level
);

  localparam int DW = uartrx_pkg::DATA_BITS;
  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int XW = (CW > uartrx_pkg::FILL_W) ? CW : uartrx_pkg::FILL_W;

  logic [DW-1:0] mem [FIFO_DEPTH];
  logic [DW-1:0] rd_q;
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] wr_ptr_inc;
  logic [PW-1:0] rd_ptr_inc;
  logic [CW-1:0] count;
  logic [CW-1:0] count_dec;
  logic [XW-1:0] count_ext;
  logic          fifo_full;
  logic          fifo_empty;
  logic          exec;
  logic          do_push;
  logic          do_pop;

  assign cmd_ready  = !cmd.is_pop || !out_valid || out_ready;
  assign exec       = cmd_valid && cmd_ready;
  assign do_push    = exec && !cmd.is_pop;
  assign do_pop     = exec && cmd.is_pop;
  assign fifo_full  = count == CW'(FIFO_DEPTH);
  assign fifo_empty = count == '0;
  assign wr_ptr_inc = (wr_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
  assign rd_ptr_inc = (rd_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
  assign count_dec  = count - CW'(1);
  assign count_ext  = XW'(count_dec);

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && !fifo_empty) begin
      rd_q <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      count      <= '0;
      out_valid  <= 1'b0;
      data_valid <= 1'b0;
      fill_level <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr_inc;
        if (fifo_full) begin
          rd_ptr <= wr_ptr_inc;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (do_pop) begin
        out_valid <= 1'b1;
        if (fifo_empty) begin
          data_valid <= 1'b0;
          fill_level <= '0;
        end else begin
          rd_ptr     <= rd_ptr_inc;
          count      <= count_dec;
          data_valid <= 1'b1;
          fill_level <= count_ext[uartrx_pkg::FILL_W-1:0];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rx_data = data_valid ? rd_q : '0;

endmodule

>>> sv/uart_receiver_frame_sync_fifo.sv
// ----------------------------------------------------------------------------
// UART receiver with receive FIFO
// Top level: front end, command queue and FIFO back end.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle. A tick item carries one sample of
// the receive line and yields no result; a pop item yields one result item,
// which passes through the command queue to the back end and is held in its
// output register until it is taken. The front end finishes each tick in the
// cycle it is accepted and passes pushes and pops through a four-entry command
// queue to the FIFO back end, which carries out one command per cycle on its
// single memory port. A pop waits in the queue while the output register holds
// an item that has not been taken, and input items stall only once the queue
// is full. Configuration registers may be written whenever no item is in
// flight; the FIFO memory needs no clearing after reset.
module uart_receiver_frame_sync_fifo #(
  parameter int FIFO_DEPTH = uartrx_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [uartrx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [uartrx_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic                                line_level,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [uartrx_pkg::DATA_BITS-1:0]    rx_data,
  output logic                                data_valid,
  output logic [uartrx_pkg::FILL_W-1:0]       fill_level
);

  logic             fq_valid;
  logic             fq_ready;
  uartrx_pkg::cmd_t fq_cmd;
  logic             qb_valid;
  logic             qb_ready;
  uartrx_pkg::cmd_t qb_cmd;

  uartrx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .line_level (line_level),
    .cmd_valid  (fq_valid),
    .cmd        (fq_cmd),
    .cmd_ready  (fq_ready)
  );

  uartrx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_cmd   (fq_cmd),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_cmd   (qb_cmd)
  );

  uartrx_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (qb_valid),
    .cmd_ready  (qb_ready),
    .cmd        (qb_cmd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rx_data    (rx_data),
    .data_valid (data_valid),
    .fill_level (fill_level)
  );

endmodule

>>> sv/uartrx_checker.sv
// ----------------------------------------------------------------------------
// UART receiver port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module uartrx_checker #(
  parameter int FIFO_DEPTH = uartrx_pkg::FIFO_DEPTH_DEFAULT
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [uartrx_pkg::DATA_BITS-1:0]  rx_data,
  input logic                              data_valid,
  input logic [uartrx_pkg::FILL_W-1:0]     fill_level
);

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rx_data) && $stable(fill_level))
    else $error("An output item was withdrawn before it was taken.");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_valid |-> rx_data == '0 && fill_level == '0)
    else $error("An empty pop returned data or a non-zero fill level.");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_valid |-> (32'(fill_level) < FIFO_DEPTH))
    else $error("A pop reported a fill level that the FIFO cannot hold.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("An output item appeared straight after reset.");

endmodule

bind uart_receiver_frame_sync_fifo uartrx_checker #(
  .FIFO_DEPTH (FIFO_DEPTH)
) u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .rx_data    (rx_data),
  .data_valid (data_valid),
  .fill_level (fill_level)
);

>>> sim/uart_receiver_frame_sync_fifo_check.sv
// ----------------------------------------------------------------------------
// UART receiver checker
// Watches the configuration port and both item channels of the UART receiver,
// keeps its own model of the bit sampler, the frame register and the receive
// FIFO, and compares every result item with the predicted reply to its pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_receiver_frame_sync_fifo_check #(
  parameter int FIFO_DEPTH = uartrx_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [uartrx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uartrx_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              req_type,
  input  logic                              line_level,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [uartrx_pkg::DATA_BITS-1:0]  rx_data,
  input  logic                              data_valid,
  input  logic [uartrx_pkg::FILL_W-1:0]     fill_level,
  output int                                mismatches,
  output int                                replies_pending,
  output int                                replies_checked,
  output int                                bytes_popped,
  output int                                bytes_overwritten
);

  typedef struct packed {
    logic [uartrx_pkg::DATA_BITS-1:0] data;
    logic                             valid;
    logic [uartrx_pkg::FILL_W-1:0]    fill;
  } pop_reply_t;

  logic                             rx_on;
  logic [15:0]                      half_ticks;
  logic                             parity_on;
  logic                             two_stop;
  logic [15:0]                      tick_count;
  logic                             second_due;
  logic                             held_level;
  logic [uartrx_pkg::FRAME_W-1:0]   frame;
  int                               frame_bits;
  logic [uartrx_pkg::DATA_BITS-1:0] fifo_mem [FIFO_DEPTH];
  int                               rd_ptr;
  int                               wr_ptr;
  logic                             fifo_at_top;
  pop_reply_t                       pop_reply_q [$];
  int                               err_count;
  int                               checked_count;
  int                               popped_count;
  int                               overwritten_count;

  function automatic int fifo_fill();
    if (fifo_at_top) return FIFO_DEPTH;
    if (wr_ptr >= rd_ptr) return wr_ptr - rd_ptr;
    return FIFO_DEPTH - rd_ptr + wr_ptr;
  endfunction

  function automatic void store_byte(logic [uartrx_pkg::DATA_BITS-1:0] value);
    logic was_full;
    was_full = (rd_ptr == wr_ptr) && fifo_at_top;
    fifo_mem[wr_ptr] = value;
    wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
    if (was_full) begin
      rd_ptr = wr_ptr;
      overwritten_count++;
    end else begin
      fifo_at_top = (rd_ptr == wr_ptr);
    end
  endfunction

  function automatic void shift_frame_bit(logic level);
    int                               width;
    logic [uartrx_pkg::FRAME_W-1:0]   mask;
    logic [uartrx_pkg::DATA_BITS-1:0] data;
    width = uartrx_pkg::FRAME_BASE + int'(two_stop) + int'(parity_on);
    frame = frame >> 1;
    if (level) frame[width-1] = 1'b1;
    if (frame_bits < width) frame_bits++;
    if (frame_bits > width) frame_bits = width;
    if (frame_bits < width) return;
    mask = '0;
    mask[0] = 1'b1;
    mask[width-1] = 1'b1;
    if (two_stop) mask[width-2] = 1'b1;
    if ((frame & mask) != (mask - 1'b1)) return;
    data = frame[uartrx_pkg::DATA_BITS:1];
    if (parity_on && (frame[width-2-int'(two_stop)] != ^data)) return;
    store_byte(data);
    frame_bits = 0;
  endfunction

  // Two agreeing samples make a bit; a disagreeing second sample starts the next bit.
  function automatic void sample_line(logic level);
    logic bit_val;
    if (!second_due) begin
      held_level = level;
      second_due = 1'b1;
    end else if (level == held_level) begin
      second_due = 1'b0;
      shift_frame_bit(level);
    end else begin
      bit_val = held_level;
      held_level = level;
      shift_frame_bit(bit_val);
    end
  endfunction

  function automatic void advance_receiver(logic level);
    int next_count;
    if (!rx_on) return;
    next_count = int'(tick_count) + 1;
    if (next_count >= int'(half_ticks)) begin
      tick_count = '0;
      sample_line(level);
    end else begin
      tick_count = 16'(next_count);
    end
  endfunction

  function automatic pop_reply_t pop_byte();
    pop_reply_t reply;
    reply = '0;
    if (rd_ptr == wr_ptr && !fifo_at_top) return reply;
    reply.data = fifo_mem[rd_ptr];
    rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
    fifo_at_top = 1'b0;
    reply.valid = 1'b1;
    reply.fill = uartrx_pkg::FILL_W'(fifo_fill());
    popped_count++;
    return reply;
  endfunction

  always @(posedge clk) begin
    pop_reply_t want;
    if (rst) begin
      rx_on = 1'b1;
      half_ticks = uartrx_pkg::HALF_BIT_RESET;
      parity_on = 1'b0;
      two_stop = 1'b0;
      tick_count = '0;
      second_due = 1'b0;
      held_level = 1'b0;
      frame = '0;
      frame_bits = 0;
      rd_ptr = 0;
      wr_ptr = 0;
      fifo_at_top = 1'b0;
      pop_reply_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pop_reply_q.size() == 0) begin
          $display("%0t: result item with no pop waiting: rx_data %02h data_valid %0d",
                   $time, rx_data, data_valid);
          err_count++;
        end else begin
          want = pop_reply_q.pop_front();
          checked_count++;
          if (rx_data !== want.data) begin
            $display("%0t: rx_data expected %02h, got %02h", $time, want.data, rx_data);
            err_count++;
          end
          if (data_valid !== want.valid) begin
            $display("%0t: data_valid expected %0d, got %0d", $time, want.valid, data_valid);
            err_count++;
          end
          if (fill_level !== want.fill) begin
            $display("%0t: fill_level expected %0d, got %0d", $time, want.fill, fill_level);
            err_count++;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          uartrx_pkg::CFG_RX_ENABLE: rx_on = cfg_data[0];
          uartrx_pkg::CFG_HALF_BIT:  half_ticks = cfg_data;
          uartrx_pkg::CFG_PARITY_EN: parity_on = cfg_data[0];
          uartrx_pkg::CFG_TWO_STOP:  two_stop = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (req_type == uartrx_pkg::REQ_TICK) advance_receiver(line_level);
        else pop_reply_q.push_back(pop_byte());
      end
    end
    mismatches <= err_count;
    replies_pending <= pop_reply_q.size();
    replies_checked <= checked_count;
    bytes_popped <= popped_count;
    bytes_overwritten <= overwritten_count;
  end

endmodule

>>> sim/uart_receiver_frame_sync_fifo_test.sv
// ----------------------------------------------------------------------------
// UART receiver regression
// Drives UART frames, line noise and pops into the receiver under a range of
// baud, parity and stop bit settings, with random idling on both channels,
// and lets the checker compare every pop result with its own prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_receiver_frame_sync_fifo_test;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 16;

  typedef enum int {FLAW_NONE, FLAW_PARITY, FLAW_STOP, FLAW_SHORT, FLAW_LONG} frame_flaw_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_write = 1'b0;
  logic [uartrx_pkg::CFG_IDX_W-1:0]  cfg_index = uartrx_pkg::CFG_RX_ENABLE;
  logic [uartrx_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic                              req_type = uartrx_pkg::REQ_TICK;
  logic                              line_level = 1'b1;
  logic                              out_valid;
  logic                              out_ready = 1'b1;
  logic [uartrx_pkg::DATA_BITS-1:0]  rx_data;
  logic                              data_valid;
  logic [uartrx_pkg::FILL_W-1:0]     fill_level;

  int   mismatches;
  int   replies_pending;
  int   replies_checked;
  int   bytes_popped;
  int   bytes_overwritten;
  int   cycle_count = 0;
  int   items_sent = 0;
  int   settings_used = 0;
  int   sample_ticks = 434;
  int   pop_pct = 0;
  logic par_on = 1'b0;
  logic stop2 = 1'b0;
  logic calm = 1'b0;

  uart_receiver_frame_sync_fifo i_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .req_type, .line_level,
    .out_valid, .out_ready, .rx_data, .data_valid, .fill_level
  );

  uart_receiver_frame_sync_fifo_check i_check (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .req_type, .line_level,
    .out_valid, .out_ready, .rx_data, .data_valid, .fill_level,
    .mismatches, .replies_pending, .replies_checked, .bytes_popped, .bytes_overwritten
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Run stopped: no progress within the cycle limit.");
    $display("uart_receiver_frame_sync_fifo regression: fail");
    $finish;
  end

  initial begin
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  task automatic send_item(logic kind, logic level);
    if (!calm && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    line_level <= level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic tick_level(logic level, int ticks);
    repeat (ticks) begin
      if ($urandom_range(0, 99) < pop_pct)
        send_item(uartrx_pkg::REQ_POP, 1'($urandom_range(0, 1)));
      send_item(uartrx_pkg::REQ_TICK, level);
    end
  endtask

  task automatic send_bit(logic level);
    tick_level(level, 2 * sample_ticks);
  endtask

  task automatic send_frame(logic [uartrx_pkg::DATA_BITS-1:0] value, frame_flaw_t flaw);
    logic [uartrx_pkg::FRAME_W-1:0] line_bits;
    int                             width;
    int                             odd_bit;
    width = uartrx_pkg::FRAME_BASE + int'(par_on) + int'(stop2);
    odd_bit = $urandom_range(0, width - 1);
    line_bits = '1;
    line_bits[0] = 1'b0;
    line_bits[uartrx_pkg::DATA_BITS:1] = value;
    if (par_on) line_bits[uartrx_pkg::DATA_BITS+1] = (^value) ^ (flaw == FLAW_PARITY);
    if (flaw == FLAW_STOP) line_bits[width-1] = 1'b0;
    for (int i = 0; i < width; i++) begin
      if (flaw == FLAW_SHORT && i == odd_bit) tick_level(line_bits[i], 2 * sample_ticks - 1);
      else if (flaw == FLAW_LONG && i == odd_bit) tick_level(line_bits[i], 2 * sample_ticks + 1);
      else send_bit(line_bits[i]);
    end
  endtask

  function automatic logic [uartrx_pkg::DATA_BITS-1:0] pick_byte();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic frame_flaw_t pick_flaw();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 82) return FLAW_NONE;
    if (pick < 87) return par_on ? FLAW_PARITY : FLAW_NONE;
    if (pick < 92) return FLAW_STOP;
    if (pick < 96) return FLAW_SHORT;
    return FLAW_LONG;
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(logic enable, logic [uartrx_pkg::CFG_DATA_W-1:0] half,
                                logic parity, logic two_stops);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= uartrx_pkg::CFG_RX_ENABLE;
    cfg_data <= uartrx_pkg::CFG_DATA_W'(enable);
    @(posedge clk);
    cfg_index <= uartrx_pkg::CFG_HALF_BIT;
    cfg_data <= half;
    @(posedge clk);
    cfg_index <= uartrx_pkg::CFG_PARITY_EN;
    cfg_data <= uartrx_pkg::CFG_DATA_W'(parity);
    @(posedge clk);
    cfg_index <= uartrx_pkg::CFG_TWO_STOP;
    cfg_data <= uartrx_pkg::CFG_DATA_W'(two_stops);
    @(posedge clk);
    cfg_write <= 1'b0;
    sample_ticks = (half == 0) ? 1 : int'(half);
    par_on = parity;
    stop2 = two_stops;
    settings_used++;
  endtask

  // Mostly well-formed frames, with bursts of noise followed by enough idle bits to
  // realign, and a partial frame at the end so the next setting starts mid-frame.
  task automatic run_frames(int budget);
    int target;
    int width;
    target = items_sent + budget;
    width = uartrx_pkg::FRAME_BASE + int'(par_on) + int'(stop2);
    repeat (width + 1) send_bit(1'b1);
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 10) begin
        repeat ($urandom_range(1, 12))
          tick_level(1'($urandom_range(0, 1)), $urandom_range(1, 2 * sample_ticks + 1));
        repeat (width + 1) send_bit(1'b1);
      end else begin
        send_frame(pick_byte(), pick_flaw());
      end
    end
    repeat ($urandom_range(1, 8)) send_bit(1'($urandom_range(0, 1)));
    repeat ($urandom_range(2, 6)) send_item(uartrx_pkg::REQ_POP, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_item(uartrx_pkg::REQ_POP, 1'b0);
    apply_settings(1'b1, 16'd0, 1'b0, 1'b0);
    send_frame(8'hA5, FLAW_NONE);
    send_item(uartrx_pkg::REQ_POP, 1'b1);
    send_item(uartrx_pkg::REQ_POP, 1'b0);

    // With a sample on every tick, a line that toggles each tick yields one bit per
    // sample, so a short run of frames overfills the FIFO.
    repeat (uartrx_pkg::FIFO_DEPTH_DEFAULT + 3) begin
      for (int i = 0; i < uartrx_pkg::FRAME_BASE; i++) tick_level(1'(i), 1);
    end
    repeat (uartrx_pkg::FIFO_DEPTH_DEFAULT + 2)
      send_item(uartrx_pkg::REQ_POP, 1'($urandom_range(0, 1)));

    pop_pct = 3;
    apply_settings(1'b1, 16'd1, 1'b1, 1'b0);
    run_frames(60);
    pop_pct = 2;
    apply_settings(1'b1, 16'd2, 1'b1, 1'b1);
    run_frames(60);

    pop_pct = 10;
    apply_settings(1'b0, 16'd3, 1'b1, 1'b0);
    tick_level(1'b0, 10);
    tick_level(1'b1, 10);
    apply_settings(1'b1, 16'hFFFF, 1'b0, 1'b1);
    repeat (20) tick_level(1'($urandom_range(0, 1)), 1);

    calm = 1'b1;
    pop_pct = 4;
    apply_settings(1'b1, 16'd1, 1'b0, 1'b1);
    run_frames(40);
    repeat (8) send_item(uartrx_pkg::REQ_POP, 1'($urandom_range(0, 1)));

    wait_idle();
    $display("Covered %0d input items over %0d receiver settings: clean and flawed frames,",
             items_sent, settings_used);
    $display("noise, FIFO overrun, a frozen receiver and the slowest baud;");
    $display("%0d pops checked, %0d bytes, %0d lost.",
             replies_checked, bytes_popped, bytes_overwritten);
    if (mismatches == 0 && replies_pending == 0) begin
      $display("uart_receiver_frame_sync_fifo regression: pass");
    end else begin
      $display("uart_receiver_frame_sync_fifo regression: fail");
    end
    $finish;
  end

endmodule
